>>> design/byte_range_lock_table_defines.svh
// assertion macros for the byte range lock table
// used by byte_range_lock_table.sv, needs signals clock and reset in scope
`ifndef BYTE_RANGE_LOCK_TABLE_DEFINES_SVH
`define BYTE_RANGE_LOCK_TABLE_DEFINES_SVH

// same-cycle implication
`define BRLT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/brlt_pkg.sv
// shared codes, defaults and sequencer state type for the byte range lock table
// no dependencies
package brlt_pkg;

   localparam int LOCK_ENTRIES_DEF = 64;
   localparam int FILE_SLOTS_DEF   = 64;
   localparam int OPEN_FILES_DEF   = 32;

   localparam logic [30:0] OFF_MAX = 31'h7fffffff;

   // request opcodes
   localparam logic [1:0] OP_QUERY  = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_WAIT   = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   // requested lock kinds
   localparam logic [2:0] K_UNLOCK = 3'd0;
   localparam logic [2:0] K_READ   = 3'd1;
   localparam logic [2:0] K_WRITE  = 3'd2;
   localparam logic [2:0] K_SHARED = 3'd3;
   localparam logic [2:0] K_EXCL   = 3'd4;

   // whence codes
   localparam logic [1:0] WH_START = 2'd0;
   localparam logic [1:0] WH_POS   = 2'd1;
   localparam logic [1:0] WH_SIZE  = 2'd2;
   localparam logic [1:0] WH_BAD   = 2'd3;

   // stored lock types
   localparam logic [1:0] LT_UNLOCK = 2'd0;
   localparam logic [1:0] LT_READ   = 2'd1;
   localparam logic [1:0] LT_WRITE  = 2'd2;

   // result status
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BADF  = 3'd1;
   localparam logic [2:0] ST_INVAL = 3'd2;
   localparam logic [2:0] ST_AGAIN = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_NOLCK = 3'd5;

   typedef enum logic [17:0] {
      S_CLEAR     = 18'h00001,
      S_IDLE      = 18'h00002,
      S_CHECK     = 18'h00004,
      S_RANGE     = 18'h00008,
      S_SCAN      = 18'h00010,
      S_SCAN_EV   = 18'h00020,
      S_FETCH     = 18'h00040,
      S_EVAL      = 18'h00080,
      S_FREE1     = 18'h00100,
      S_FREE2     = 18'h00200,
      S_POST      = 18'h00400,
      S_AL_RD     = 18'h00800,
      S_AL_WR     = 18'h01000,
      S_AL_LN     = 18'h02000,
      S_SPLIT_CHK = 18'h04000,
      S_FIX_R     = 18'h08000,
      S_FIX_L     = 18'h10000,
      S_DONE      = 18'h20000
   } brlt_state_type;

endpackage

>>> design/byte_range_lock_table.sv
// byte range lock table: pool of lock entries on per-file linked lists,
// walked one entry at a time by a sequencer over an entry memory with one
// read and one write port; one item at a time: a new request is taken only
// in idle, once the previous result has gone to the output register.
// reset: a clearing pass over max(LOCK_ENTRIES, FILE_SLOTS) addresses builds
// the free list and empties the file lists; no item is taken meanwhile.
`include "byte_range_lock_table_defines.svh"

module byte_range_lock_table
   import brlt_pkg::*;
#(
   parameter int LOCK_ENTRIES = LOCK_ENTRIES_DEF,
   parameter int FILE_SLOTS   = FILE_SLOTS_DEF,
   parameter int OPEN_FILES   = OPEN_FILES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, file_id, owner_id, descriptor, lock_kind, whence, rel_start,
   // length, file_pos, file_size, access_mode, is_regular
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, conflict_type, conflict_owner, conflict_start, conflict_length
   output logic [87:0]  rsp_tdata
);

   localparam int EW    = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
   localparam int IW    = $clog2(LOCK_ENTRIES + 1);
   localparam int FW    = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
   localparam int CLR_N = (LOCK_ENTRIES > FILE_SLOTS) ? LOCK_ENTRIES : FILE_SLOTS;
   localparam int CW    = $clog2(CLR_N);
   localparam logic [IW-1:0] NIL_IDX = IW'(LOCK_ENTRIES);

   typedef struct packed {
      logic [15:0]   owner;
      logic [7:0]    desc;
      logic [1:0]    kind;
      logic [30:0]   lo;
      logic [30:0]   hi;
      logic [IW-1:0] link;
   } entry_w_type;

   entry_w_type   ent_mem [LOCK_ENTRIES];
   logic [IW-1:0] head_mem [FILE_SLOTS];

   brlt_state_type state_ff, state_in;
   logic [CW-1:0]  clr_ff, clr_in;
   logic [1:0]     op_ff, op_in;
   logic [5:0]     fid_ff, fid_in;
   logic [15:0]    own_ff, own_in;
   logic [7:0]     fd_ff, fd_in;
   logic [2:0]     kind_ff, kind_in;
   logic [1:0]     wh_ff, wh_in;
   logic [31:0]    rs_ff, rs_in;
   logic [31:0]    len_ff, len_in;
   logic [30:0]    fpos_ff, fpos_in;
   logic [30:0]    fsize_ff, fsize_in;
   logic [1:0]     mode_ff, mode_in;
   logic           reg_ff, reg_in;
   logic [33:0]    ssum_ff, ssum_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  free_ff, free_in;
   logic [IW-1:0]  prev_ff, prev_in;
   entry_w_type    prev_w_ff, prev_w_in;
   logic [IW-1:0]  cur_ff, cur_in;
   entry_w_type    cur_w_ff, cur_w_in;
   logic [IW-1:0]  cidx_ff, cidx_in;
   entry_w_type    c_w_ff, c_w_in;
   logic [IW-1:0]  left_ff, left_in;
   entry_w_type    left_w_ff, left_w_in;
   logic [IW-1:0]  right_ff, right_in;
   entry_w_type    right_w_ff, right_w_in;
   logic           skip_ff, skip_in;
   logic           added_ff, added_in;
   logic           split_ff, split_in;
   logic           fail_ff, fail_in;
   logic [2:0]     res_st_ff, res_st_in;
   logic [1:0]     res_ty_ff, res_ty_in;
   logic [15:0]    res_own_ff, res_own_in;
   logic [30:0]    res_lo_ff, res_lo_in;
   logic [30:0]    res_len_ff, res_len_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [87:0]    rsp_data_ff, rsp_data_in;
   entry_w_type    rd_q_ff;
   logic [IW-1:0]  hd_q_ff;

   logic           ent_we;
   logic [EW-1:0]  ent_wa;
   entry_w_type    ent_wd;
   logic           head_we;
   logic [FW-1:0]  head_wa;
   logic [IW-1:0]  head_wd;
   logic [EW-1:0]  rd_addr;
   logic [FW-1:0]  hd_ra;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign hd_ra      = FW'(req_tdata[7:2]);

   // memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      rd_q_ff <= ent_mem[rd_addr];
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      hd_q_ff <= head_mem[hd_ra];
   end

   always_comb begin
      logic [30:0]   base;
      logic [30:0]   s_val;
      logic [32:0]   t_sum;
      logic [30:0]   e_val;
      logic [1:0]    ty;
      logic          acc_ok;
      logic [IW-1:0] nxt;
      entry_w_type   w;
      entry_w_type   nw;
      logic          match;
      logic [30:0]   mn;
      logic [30:0]   mx;
      logic          added_n;

      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      fid_in      = fid_ff;
      own_in      = own_ff;
      fd_in       = fd_ff;
      kind_in     = kind_ff;
      wh_in       = wh_ff;
      rs_in       = rs_ff;
      len_in      = len_ff;
      fpos_in     = fpos_ff;
      fsize_in    = fsize_ff;
      mode_in     = mode_ff;
      reg_in      = reg_ff;
      ssum_in     = ssum_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      prev_in     = prev_ff;
      prev_w_in   = prev_w_ff;
      cur_in      = cur_ff;
      cur_w_in    = cur_w_ff;
      cidx_in     = cidx_ff;
      c_w_in      = c_w_ff;
      left_in     = left_ff;
      left_w_in   = left_w_ff;
      right_in    = right_ff;
      right_w_in  = right_w_ff;
      skip_in     = skip_ff;
      added_in    = added_ff;
      split_in    = split_ff;
      fail_in     = fail_ff;
      res_st_in   = res_st_ff;
      res_ty_in   = res_ty_ff;
      res_own_in  = res_own_ff;
      res_lo_in   = res_lo_ff;
      res_len_in  = res_len_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;

      ent_we  = 1'b0;
      ent_wa  = '0;
      ent_wd  = '0;
      head_we = 1'b0;
      head_wa = FW'(fid_ff);
      head_wd = '0;
      rd_addr = '0;

      base    = '0;
      s_val   = '0;
      t_sum   = '0;
      e_val   = '0;
      ty      = LT_UNLOCK;
      acc_ok  = 1'b1;
      nxt     = (prev_ff == NIL_IDX) ? head_ff : prev_w_ff.link;
      w       = rd_q_ff;
      nw      = rd_q_ff;
      match   = (rd_q_ff.owner == own_ff) && (rd_q_ff.desc == fd_ff);
      mn      = (rd_q_ff.lo > c_w_ff.lo) ? c_w_ff.lo : rd_q_ff.lo;
      mx      = (rd_q_ff.hi < c_w_ff.hi) ? c_w_ff.hi : rd_q_ff.hi;
      added_n = added_ff || (c_w_ff.kind == LT_UNLOCK);

      case (state_ff)
         S_CLEAR: begin
            // build the free chain and empty every file list
            if (32'(clr_ff) < LOCK_ENTRIES) begin
               ent_we      = 1'b1;
               ent_wa      = clr_ff[EW-1:0];
               ent_wd      = '0;
               ent_wd.link = IW'(clr_ff) + IW'(1);
            end
            if (32'(clr_ff) < FILE_SLOTS) begin
               head_we = 1'b1;
               head_wa = clr_ff[FW-1:0];
               head_wd = NIL_IDX;
            end
            if (32'(clr_ff) == CLR_N - 1) begin
               state_in = S_IDLE;
            end
            clr_in = clr_ff + CW'(1);
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tdata[1:0];
               fid_in     = req_tdata[7:2];
               own_in     = req_tdata[23:8];
               fd_in      = req_tdata[31:24];
               kind_in    = req_tdata[34:32];
               wh_in      = req_tdata[36:35];
               rs_in      = req_tdata[68:37];
               len_in     = req_tdata[100:69];
               fpos_in    = req_tdata[131:101];
               fsize_in   = req_tdata[162:132];
               mode_in    = req_tdata[164:163];
               reg_in     = req_tdata[165];
               res_st_in  = ST_OK;
               res_ty_in  = '0;
               res_own_in = '0;
               res_lo_in  = '0;
               res_len_in = '0;
               prev_in    = NIL_IDX;
               cidx_in    = NIL_IDX;
               left_in    = NIL_IDX;
               right_in   = NIL_IDX;
               skip_in    = 1'b1;
               added_in   = 1'b0;
               fail_in    = 1'b0;
               split_in   = 1'b0;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            head_in = hd_q_ff;
            case (wh_ff)
               WH_POS:  base = fpos_ff;
               WH_SIZE: base = fsize_ff;
               default: base = '0;
            endcase
            ssum_in = {3'b000, base} + {{2{rs_ff[31]}}, rs_ff};
            if (32'(fid_ff) >= FILE_SLOTS) begin
               res_st_in = ST_BADF;
               state_in  = S_DONE;
            end else if (op_ff == OP_REMOVE) begin
               state_in = S_FETCH;
            end else if (32'(fd_ff) >= OPEN_FILES) begin
               res_st_in = ST_BADF;
               state_in  = S_DONE;
            end else if ((op_ff == OP_QUERY && kind_ff == K_UNLOCK) || !reg_ff ||
                         kind_ff > K_EXCL || wh_ff == WH_BAD) begin
               res_st_in = ST_INVAL;
               state_in  = S_DONE;
            end else begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            s_val = ssum_ff[30:0];
            t_sum = {2'b00, s_val} + {2'b00, len_ff[30:0]} - 33'd1;
            e_val = (len_ff == '0 || t_sum[32:31] != 2'b00) ? OFF_MAX : t_sum[30:0];
            case (kind_ff)
               K_READ, K_SHARED: ty = LT_READ;
               K_WRITE, K_EXCL:  ty = LT_WRITE;
               default:          ty = LT_UNLOCK;
            endcase
            case (kind_ff)
               K_READ:           acc_ok = mode_ff[0];
               K_WRITE:          acc_ok = mode_ff[1];
               K_SHARED, K_EXCL: acc_ok = (mode_ff != 2'b00);
               default:          acc_ok = 1'b1;
            endcase
            c_w_in       = '0;
            c_w_in.owner = own_ff;
            c_w_in.desc  = fd_ff;
            c_w_in.kind  = ty;
            c_w_in.lo    = s_val;
            c_w_in.hi    = e_val;
            cur_in       = head_ff;
            if (ssum_ff[33] || ssum_ff[32:31] != 2'b00 || len_ff[31]) begin
               res_st_in = ST_INVAL;
               state_in  = S_DONE;
            end else if (op_ff != OP_QUERY && !acc_ok) begin
               res_st_in = ST_BADF;
               state_in  = S_DONE;
            end else if (ty != LT_UNLOCK) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_SCAN: begin
            rd_addr = cur_ff[EW-1:0];
            if (cur_ff == NIL_IDX) begin
               state_in = (op_ff == OP_QUERY) ? S_DONE : S_FETCH;
            end else begin
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cur_in   = w.link;
            state_in = S_SCAN;
            if (!match && w.lo <= c_w_ff.hi && w.hi >= c_w_ff.lo &&
                (c_w_ff.kind == LT_WRITE || w.kind != LT_READ)) begin
               state_in = S_DONE;
               if (op_ff == OP_QUERY) begin
                  res_ty_in  = w.kind;
                  res_own_in = w.owner;
                  res_lo_in  = w.lo;
                  res_len_in = (w.hi == OFF_MAX) ? '0 : (w.hi - w.lo + 31'd1);
               end else begin
                  res_st_in = (op_ff == OP_WAIT) ? ST_WAIT : ST_AGAIN;
               end
            end
         end
         S_FETCH: begin
            rd_addr = nxt[EW-1:0];
            cur_in  = nxt;
            if (nxt == NIL_IDX) begin
               state_in = (op_ff == OP_REMOVE) ? S_DONE : S_POST;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cur_w_in = w;
            if (!match) begin
               if (skip_ff) begin
                  prev_in   = cur_ff;
                  prev_w_in = w;
                  state_in  = S_FETCH;
               end else begin
                  state_in = (op_ff == OP_REMOVE) ? S_DONE : S_POST;
               end
            end else begin
               skip_in = 1'b0;
               if (op_ff == OP_REMOVE) begin
                  state_in = S_FREE1;
               end else if (c_w_ff.kind == w.kind) begin
                  if ({1'b0, w.hi} + 32'd1 < {1'b0, c_w_ff.lo}) begin
                     prev_in   = cur_ff;
                     prev_w_in = w;
                     state_in  = S_FETCH;
                  end else if (c_w_ff.hi < OFF_MAX &&
                               {1'b0, w.lo} > {1'b0, c_w_ff.hi} + 32'd1) begin
                     state_in = S_POST;
                  end else if (added_ff) begin
                     // fold into the entry already holding the request
                     c_w_in.lo = mn;
                     c_w_in.hi = mx;
                     if (cidx_ff != NIL_IDX) begin
                        ent_we = 1'b1;
                        ent_wa = cidx_ff[EW-1:0];
                        ent_wd = c_w_in;
                     end
                     state_in = S_FREE1;
                  end else begin
                     nw.lo     = mn;
                     nw.hi     = mx;
                     ent_we    = 1'b1;
                     ent_wa    = cur_ff[EW-1:0];
                     ent_wd    = nw;
                     cidx_in   = cur_ff;
                     c_w_in    = nw;
                     added_in  = 1'b1;
                     prev_in   = cur_ff;
                     prev_w_in = nw;
                     state_in  = S_FETCH;
                  end
               end else begin
                  if (w.hi < c_w_ff.lo) begin
                     prev_in   = cur_ff;
                     prev_w_in = w;
                     state_in  = S_FETCH;
                  end else if (w.lo > c_w_ff.hi) begin
                     state_in = S_POST;
                  end else begin
                     added_in = added_n;
                     if (w.lo < c_w_ff.lo) begin
                        left_in   = cur_ff;
                        left_w_in = w;
                     end
                     if (w.hi > c_w_ff.hi) begin
                        right_in   = cur_ff;
                        right_w_in = w;
                        state_in   = S_POST;
                     end else if (w.lo >= c_w_ff.lo) begin
                        if (added_n) begin
                           state_in = S_FREE1;
                        end else begin
                           // covered entry takes over the request
                           nw.lo     = c_w_ff.lo;
                           nw.hi     = c_w_ff.hi;
                           nw.kind   = c_w_ff.kind;
                           ent_we    = 1'b1;
                           ent_wa    = cur_ff[EW-1:0];
                           ent_wd    = nw;
                           cidx_in   = cur_ff;
                           c_w_in    = nw;
                           added_in  = 1'b1;
                           prev_in   = cur_ff;
                           prev_w_in = nw;
                           state_in  = S_FETCH;
                        end
                     end else begin
                        prev_in   = cur_ff;
                        prev_w_in = w;
                        state_in  = S_FETCH;
                     end
                  end
               end
            end
         end
         S_FREE1: begin
            // unlink the entry after prev
            if (prev_ff == NIL_IDX) begin
               head_we = 1'b1;
               head_wd = cur_w_ff.link;
               head_in = cur_w_ff.link;
            end else begin
               ent_we      = 1'b1;
               ent_wa      = prev_ff[EW-1:0];
               ent_wd      = prev_w_ff;
               ent_wd.link = cur_w_ff.link;
            end
            state_in = S_FREE2;
         end
         S_FREE2: begin
            ent_we      = 1'b1;
            ent_wa      = cur_ff[EW-1:0];
            ent_wd      = cur_w_ff;
            ent_wd.link = free_ff;
            free_in     = cur_ff;
            if (fail_ff) begin
               res_st_in = ST_NOLCK;
               state_in  = S_DONE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_POST: begin
            if (added_ff) begin
               state_in = S_SPLIT_CHK;
            end else if (c_w_ff.kind == LT_UNLOCK) begin
               res_st_in = ST_INVAL;
               state_in  = S_DONE;
            end else begin
               split_in = 1'b0;
               state_in = S_AL_RD;
            end
         end
         S_AL_RD: begin
            rd_addr = free_ff[EW-1:0];
            if (free_ff == NIL_IDX) begin
               if (split_ff && !added_ff) begin
                  // drop the entry made for the request
                  cur_in   = cidx_ff;
                  cur_w_in = c_w_ff;
                  fail_in  = 1'b1;
                  state_in = S_FREE1;
               end else begin
                  res_st_in = ST_NOLCK;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_AL_WR;
            end
         end
         S_AL_WR: begin
            free_in  = rd_q_ff.link;
            nw       = split_ff ? right_w_ff : c_w_ff;
            nw.owner = own_ff;
            nw.desc  = fd_ff;
            nw.link  = nxt;
            ent_we   = 1'b1;
            ent_wa   = free_ff[EW-1:0];
            ent_wd   = nw;
            cur_in   = free_ff;
            if (split_ff) begin
               left_in   = free_ff;
               left_w_in = nw;
            end else begin
               cidx_in = free_ff;
               c_w_in  = nw;
            end
            state_in = S_AL_LN;
         end
         S_AL_LN: begin
            if (prev_ff == NIL_IDX) begin
               head_we = 1'b1;
               head_wd = cur_ff;
               head_in = cur_ff;
            end else begin
               ent_we      = 1'b1;
               ent_wa      = prev_ff[EW-1:0];
               ent_wd      = prev_w_ff;
               ent_wd.link = cur_ff;
            end
            state_in = split_ff ? S_FIX_R : S_SPLIT_CHK;
         end
         S_SPLIT_CHK: begin
            if (right_ff != NIL_IDX) begin
               if (left_ff == right_ff) begin
                  split_in = 1'b1;
                  state_in = S_AL_RD;
               end else begin
                  state_in = S_FIX_R;
               end
            end else begin
               state_in = S_FIX_L;
            end
         end
         S_FIX_R: begin
            ent_we    = 1'b1;
            ent_wa    = right_ff[EW-1:0];
            ent_wd    = right_w_ff;
            ent_wd.lo = c_w_ff.hi + 31'd1;
            state_in  = S_FIX_L;
         end
         S_FIX_L: begin
            if (left_ff != NIL_IDX) begin
               ent_we    = 1'b1;
               ent_wa    = left_ff[EW-1:0];
               ent_wd    = left_w_ff;
               ent_wd.hi = c_w_ff.lo - 31'd1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b00000, res_len_ff, res_lo_ff, res_own_ff,
                               res_ty_ff, res_st_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // keep cached entry words in step with the memory
      if (ent_we) begin
         if (prev_in == IW'(ent_wa)) prev_w_in = ent_wd;
         if (cur_in == IW'(ent_wa)) cur_w_in = ent_wd;
         if (cidx_in == IW'(ent_wa)) c_w_in = ent_wd;
         if (left_in == IW'(ent_wa)) left_w_in = ent_wd;
         if (right_in == IW'(ent_wa)) right_w_in = ent_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      fid_ff      <= fid_in;
      own_ff      <= own_in;
      fd_ff       <= fd_in;
      kind_ff     <= kind_in;
      wh_ff       <= wh_in;
      rs_ff       <= rs_in;
      len_ff      <= len_in;
      fpos_ff     <= fpos_in;
      fsize_ff    <= fsize_in;
      mode_ff     <= mode_in;
      reg_ff      <= reg_in;
      ssum_ff     <= ssum_in;
      head_ff     <= head_in;
      prev_ff     <= prev_in;
      prev_w_ff   <= prev_w_in;
      cur_ff      <= cur_in;
      cur_w_ff    <= cur_w_in;
      cidx_ff     <= cidx_in;
      c_w_ff      <= c_w_in;
      left_ff     <= left_in;
      left_w_ff   <= left_w_in;
      right_ff    <= right_in;
      right_w_ff  <= right_w_in;
      skip_ff     <= skip_in;
      added_ff    <= added_in;
      split_ff    <= split_in;
      fail_ff     <= fail_in;
      res_st_ff   <= res_st_in;
      res_ty_ff   <= res_ty_in;
      res_own_ff  <= res_own_in;
      res_lo_ff   <= res_lo_in;
      res_len_ff  <= res_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   `BRLT_ASSERT_NOW(a_free_range, state_ff != S_CLEAR, free_ff <= NIL_IDX, "free head out of range")
   `BRLT_ASSERT_NEXT(a_accept_check, req_tvalid && req_tready, state_ff == S_CHECK, "accept did not start check")
   `BRLT_ASSERT_NEXT(a_done_out, state_ff == S_DONE && (!rsp_valid_ff || rsp_tready), rsp_tvalid && state_ff == S_IDLE, "result not presented")
   `BRLT_ASSERT_NOW(a_clear_block, state_ff == S_CLEAR, !req_tready && !rsp_tvalid, "activity during clearing pass")

endmodule
